// File: sv/dq_pkg.sv
`default_nettype none

package dq_pkg;

    // defaults for the top-level parameters
    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // fixed field widths of the request and response items
    localparam int ACTION_W = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_PEEK_BACK  = 3'd5;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // per-cell command: load the new word, or take a neighbor's word
    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: sv/dq_req_if.sv
`default_nettype none

interface dq_req_if import dq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   data_in;

    modport source (output valid, output action, output data_in, input ready);
    modport sink   (input valid, input action, input data_in, output ready);
endinterface

`default_nettype wire

// File: sv/dq_rsp_if.sv
`default_nettype none

interface dq_rsp_if import dq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   data_out;
    logic                is_empty;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output data_out, output is_empty, output status, input ready);
    modport sink   (input valid, input data_out, input is_empty, input status, output ready);
endinterface

`default_nettype wire

// File: sv/dq_cell.sv
`default_nettype none

// one storage cell of the chain; shifts with its neighbors
module dq_cell import dq_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire cell_cmd_t             cmd,
    input  wire logic [DATA_WIDTH-1:0] word,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    output logic      [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.load)
        begin
            data_next = word;
        end
        else if (cmd.take_left)
        begin
            data_next = left_data;
        end
        else if (cmd.take_right)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: sv/dq_chain.sv
`default_nettype none

// row of cells, front item always in cell 0; back read by one-hot select
module dq_chain import dq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire cell_cmd_t             cmd [DEPTH],
    input  wire logic [DATA_WIDTH-1:0] word,
    input  wire logic [DEPTH-1:0]      back_sel,
    output logic      [DATA_WIDTH-1:0] front_data,
    output logic      [DATA_WIDTH-1:0] back_data
);

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = word;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        dq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd[i]),
            .word       (word),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    assign front_data = cell_data[0];

    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_data = back_data | (cell_data[i] & {DATA_WIDTH{back_sel[i]}});
        end
    end

endmodule

`default_nettype wire

// File: sv/double_ended_queue_core.sv
`default_nettype none

// Bounded double-ended queue of DEPTH words of DATA_WIDTH bits. Each request
// pushes at the front or back, pops from either end or peeks at either end,
// and yields exactly one response with the word read (zero if none), an
// empty flag for the state after the request, and a status: ok, underflow
// (pop/peek on empty, nothing changes) or overflow (push on full, refused).
// Codes 6 and 7 do nothing and answer ok. Storage is a chain of cells with
// the front item always held in cell 0: a front push shifts the chain one
// cell back, a front pop shifts it one cell forward, a back push loads the
// cell just past the last item, and a back pop only lowers the count. The
// back item is picked out of the chain by a one-hot select on the count.
// Timing: one request per clock while responses are taken; the response is
// registered in the cycle after acceptance. A new request is taken while the
// previous response is being taken in the same cycle; a response that is
// held stalls the request side. The storage needs no clearing after reset.
// Pushed words are zero-extended or cut to DATA_WIDTH bits; read words are
// zero-extended or cut to the 32-bit response field.
module double_ended_queue_core import dq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    dq_req_if.sink   req,
    dq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // item count: the only control state; the front is fixed at cell 0
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic rsp_valid_reg;
    logic [WORD_W-1:0]   data_out_reg;
    logic                is_empty_reg;
    logic [STATUS_W-1:0] status_reg;

    logic fire;
    logic full;
    logic empty;

    logic do_push_front;
    logic do_push_back;
    logic do_pop_front;
    logic rd_front;
    logic rd_back;
    logic [STATUS_W-1:0] st;

    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] front_data;
    logic [DATA_WIDTH-1:0] back_data;
    logic [DATA_WIDTH-1:0] rd_word;
    logic [DEPTH-1:0]      back_sel;
    logic [DEPTH-1:0]      tail_sel;
    cell_cmd_t             cmd [DEPTH];

    logic [WORD_W+DATA_WIDTH-1:0] in_ext;
    logic [WORD_W+DATA_WIDTH-1:0] out_ext;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // zero-extend or cut the incoming word to the storage width
    assign in_ext = {{DATA_WIDTH{1'b0}}, req.data_in};
    assign word   = in_ext[DATA_WIDTH-1:0];

    // request decode
    always_comb
    begin
        do_push_front = 1'b0;
        do_push_back  = 1'b0;
        do_pop_front  = 1'b0;
        rd_front      = 1'b0;
        rd_back       = 1'b0;
        st            = ST_OK;
        count_next    = count_reg;
        case (req.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (full)
                begin
                    st = ST_OVERFLOW;
                end
                else
                begin
                    do_push_front = (req.action == ACT_PUSH_FRONT);
                    do_push_back  = (req.action == ACT_PUSH_BACK);
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            ACT_POP_FRONT, ACT_PEEK_FRONT:
            begin
                if (empty)
                begin
                    st = ST_UNDERFLOW;
                end
                else
                begin
                    rd_front = 1'b1;
                    if (req.action == ACT_POP_FRONT)
                    begin
                        do_pop_front = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
            end
            ACT_POP_BACK, ACT_PEEK_BACK:
            begin
                if (empty)
                begin
                    st = ST_UNDERFLOW;
                end
                else
                begin
                    rd_back = 1'b1;
                    if (req.action == ACT_POP_BACK)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    // per-cell commands: back_sel marks the last item, tail_sel the first free cell
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cmd
        assign back_sel[i] = (count_reg == CNT_W'(i + 1));
        assign tail_sel[i] = (count_reg == CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign cmd[i].load      = fire && (do_push_front || (do_push_back && tail_sel[i]));
            assign cmd[i].take_left = 1'b0;
        end
        else
        begin : g_body
            assign cmd[i].load      = fire && do_push_back && tail_sel[i];
            assign cmd[i].take_left = fire && do_push_front;
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign cmd[i].take_right = 1'b0;
        end
        else
        begin : g_inner
            assign cmd[i].take_right = fire && do_pop_front;
        end
    end

    dq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_chain (
        .clk        (clk),
        .cmd        (cmd),
        .word       (word),
        .back_sel   (back_sel),
        .front_data (front_data),
        .back_data  (back_data)
    );

    // zero when nothing is read
    assign rd_word = rd_front ? front_data : (rd_back ? back_data : '0);
    assign out_ext = {{WORD_W{1'b0}}, rd_word};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_out_reg <= out_ext[WORD_W-1:0];
            is_empty_reg <= (count_next == '0);
            status_reg   <= st;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.data_out = data_out_reg;
    assign rsp.is_empty = is_empty_reg;
    assign rsp.status   = status_reg;

endmodule

`default_nettype wire
